// ----- rtl/wbrp_pkg.sv -----
// Shared types and constants for the write batch record parser.
// No dependencies; imported by every module of the block.
package wbrp_pkg;

  // Parse phases, one-hot.
  typedef enum logic [6:0] {
    PH_HEADER  = 7'b0000001,
    PH_TYPE    = 7'b0000010,
    PH_KEYLEN  = 7'b0000100,
    PH_KEY     = 7'b0001000,
    PH_VALLEN  = 7'b0010000,
    PH_VAL     = 7'b0100000,
    PH_DISCARD = 7'b1000000
  } phase_e;

  // Result kinds.
  localparam logic [2:0] KIND_SEQ      = 3'd0;
  localparam logic [2:0] KIND_OP_START = 3'd1;
  localparam logic [2:0] KIND_KEY      = 3'd2;
  localparam logic [2:0] KIND_VALUE    = 3'd3;
  localparam logic [2:0] KIND_MARKER   = 3'd4;

  // Operation codes.
  localparam logic [1:0] OP_DELETE = 2'd0;
  localparam logic [1:0] OP_PUT    = 2'd1;
  localparam logic [1:0] OP_MERGE  = 2'd2;

  localparam int unsigned LEN_W   = 56;
  localparam int unsigned GROUP_W = 4;
  localparam int unsigned QDEPTH  = 4;

  // Marker key, zero filled beyond its 28 characters.
  localparam logic [7:0] MARKER_KEY [32] = '{
    8'h7E, 8'h73, 8'h6C, 8'h61, 8'h76, 8'h65, 8'h2D, 8'h6C,
    8'h61, 8'h73, 8'h74, 8'h2D, 8'h73, 8'h65, 8'h71, 8'h75,
    8'h65, 8'h6E, 8'h63, 8'h65, 8'h2D, 8'h6E, 8'h75, 8'h6D,
    8'h62, 8'h65, 8'h72, 8'h7E, 8'h00, 8'h00, 8'h00, 8'h00
  };

  typedef struct packed {
    logic [2:0]  kind;
    logic [1:0]  op_code;
    logic [7:0]  payload_byte;
    logic [31:0] sequence_number;
    logic        op_end;
    logic        op_accepted;
    logic        record_end;
    logic        format_error;
  } result_t;

endpackage

// ----- rtl/wbrp_front.sv -----
// Front end of the record parser: accepts bytes and classifies them into results.
// Depends on wbrp_pkg.
module wbrp_front #(
  parameter int unsigned HEADER_BYTES      = 12,
  parameter int unsigned MAX_VARINT_GROUPS = 8,
  parameter int unsigned MARKER_KEY_LENGTH = 28
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  logic [7:0]        data_i,
  input  logic              last_i,
  input  logic              q_full_i,
  output logic              push_o,
  output wbrp_pkg::result_t res_o
);
  import wbrp_pkg::*;

  phase_e             phase_q, phase_d;
  logic [3:0]         hpos_q, hpos_d;
  logic [23:0]        seqp_q, seqp_d;
  logic [GROUP_W-1:0] grp_q, grp_d;
  logic [LEN_W-1:0]   len_q, len_d;
  logic [1:0]         op_q, op_d;
  logic [4:0]         mpos_q, mpos_d;
  logic               mm_q, mm_d;
  logic               kne_q, kne_d;

  logic               accept;
  logic               emit;
  result_t            res;
  logic [LEN_W-1:0]   len_new;
  logic [LEN_W-1:0]   len_dec;
  logic [GROUP_W-1:0] grp_next;
  logic               vdone;
  logic               hdr_done;
  logic               is_key;
  logic               err;
  logic               mm_new;

  assign ready_o = !q_full_i;
  assign accept  = valid_i && ready_o;
  assign push_o  = accept && emit;
  assign res_o   = res;

  always_comb begin
    len_new = len_q;
    for (int i = 0; i < 8; i++) begin
      if (grp_q == GROUP_W'(i)) begin
        len_new[7*i +: 7] = len_q[7*i +: 7] | data_i[6:0];
      end
    end
  end

  assign grp_next = grp_q + GROUP_W'(1);
  assign vdone    = !data_i[7] || (grp_next >= GROUP_W'(MAX_VARINT_GROUPS));
  assign hdr_done = ({1'b0, hpos_q} + 5'd1) >= 5'(HEADER_BYTES);
  assign is_key   = (phase_q == PH_KEYLEN);
  assign len_dec  = (len_q != '0) ? len_q - LEN_W'(1) : len_q;

  always_comb begin
    phase_d = phase_q;
    hpos_d  = hpos_q;
    seqp_d  = seqp_q;
    grp_d   = grp_q;
    len_d   = len_q;
    op_d    = op_q;
    mpos_d  = mpos_q;
    mm_d    = mm_q;
    kne_d   = kne_q;
    emit    = 1'b0;
    res     = '0;
    res.record_end = last_i;
    err     = 1'b0;
    mm_new  = mm_q;

    case (phase_q)
      PH_HEADER: begin
        if (hpos_q < 4'd3) begin
          seqp_d[8*hpos_q[1:0] +: 8] = data_i;
        end
        if (hpos_q == 4'd3) begin
          res.sequence_number = {data_i, seqp_q};
          res.kind            = KIND_SEQ;
          emit                = 1'b1;
        end else begin
          res.kind = KIND_MARKER;
        end
        if (last_i) begin
          emit             = 1'b1;
          res.format_error = !hdr_done;
        end else if (hdr_done) begin
          phase_d = PH_TYPE;
        end else begin
          hpos_d = hpos_q + 4'd1;
        end
      end

      PH_TYPE: begin
        emit = 1'b1;
        if (data_i > 8'd2) begin
          res.kind         = KIND_MARKER;
          res.format_error = 1'b1;
          phase_d          = PH_DISCARD;
        end else begin
          op_d             = data_i[1:0];
          kne_d            = 1'b0;
          mm_d             = 1'b0;
          mpos_d           = '0;
          phase_d          = PH_KEYLEN;
          grp_d            = '0;
          len_d            = '0;
          res.kind         = KIND_OP_START;
          res.op_code      = data_i[1:0];
          res.format_error = last_i;
        end
      end

      PH_KEYLEN, PH_VALLEN: begin
        res.kind    = KIND_MARKER;
        res.op_code = op_q;
        grp_d       = grp_next;
        len_d       = len_new;
        if (last_i) begin
          err = data_i[7] || (len_new != '0) || (is_key && (op_q != OP_DELETE));
          emit             = 1'b1;
          res.op_end       = !err;
          res.op_accepted  = !err && !is_key && kne_q && mm_q;
          res.format_error = err;
        end else if (vdone) begin
          if (is_key) begin
            kne_d  = (len_new != '0);
            mm_d   = (len_new != LEN_W'(MARKER_KEY_LENGTH));
            mpos_d = '0;
            if (len_new != '0) begin
              phase_d = PH_KEY;
            end else if (op_q == OP_DELETE) begin
              phase_d    = PH_TYPE;
              emit       = 1'b1;
              res.op_end = 1'b1;
            end else begin
              phase_d = PH_VALLEN;
              grp_d   = '0;
              len_d   = '0;
            end
          end else if (len_new != '0) begin
            phase_d = PH_VAL;
          end else begin
            phase_d         = PH_TYPE;
            emit            = 1'b1;
            res.op_end      = 1'b1;
            res.op_accepted = kne_q && mm_q;
          end
        end
      end

      PH_KEY: begin
        emit             = 1'b1;
        res.kind         = KIND_KEY;
        res.op_code      = op_q;
        res.payload_byte = data_i;
        if (!mm_q) begin
          mm_new = (data_i != MARKER_KEY[mpos_q]);
          mpos_d = mpos_q + 5'd1;
        end
        mm_d  = mm_new;
        len_d = len_dec;
        if (len_dec == '0) begin
          if (op_q == OP_DELETE) begin
            res.op_end      = 1'b1;
            res.op_accepted = kne_q && mm_new;
            phase_d         = PH_TYPE;
          end else begin
            phase_d = PH_VALLEN;
            grp_d   = '0;
            len_d   = '0;
          end
        end
        res.format_error = last_i && !res.op_end;
      end

      PH_VAL: begin
        emit             = 1'b1;
        res.kind         = KIND_VALUE;
        res.op_code      = op_q;
        res.payload_byte = data_i;
        len_d            = len_dec;
        if (len_dec == '0) begin
          res.op_end      = 1'b1;
          res.op_accepted = kne_q && mm_q;
          phase_d         = PH_TYPE;
        end
        res.format_error = last_i && !res.op_end;
      end

      default: begin
        res.kind = KIND_MARKER;
        emit     = last_i;
        phase_d  = PH_DISCARD;
      end
    endcase

    // Clear all parse state at the record's last byte.
    if (last_i) begin
      phase_d = PH_HEADER;
      hpos_d  = '0;
      seqp_d  = '0;
      grp_d   = '0;
      len_d   = '0;
      op_d    = '0;
      mpos_d  = '0;
      mm_d    = 1'b0;
      kne_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      hpos_q  <= '0;
      seqp_q  <= '0;
      grp_q   <= '0;
      len_q   <= '0;
      op_q    <= '0;
      mpos_q  <= '0;
      mm_q    <= 1'b0;
      kne_q   <= 1'b0;
    end else if (accept) begin
      phase_q <= phase_d;
      hpos_q  <= hpos_d;
      seqp_q  <= seqp_d;
      grp_q   <= grp_d;
      len_q   <= len_d;
      op_q    <= op_d;
      mpos_q  <= mpos_d;
      mm_q    <= mm_d;
      kne_q   <= kne_d;
    end
  end

  a_last_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && last_i |-> push_o && res.record_end)
    else $error("last byte accepted without a record end result");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && last_i |=> phase_q == PH_HEADER && hpos_q == '0 && len_q == '0)
    else $error("parse state not cleared after record end");

  a_group_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    grp_q <= GROUP_W'(MAX_VARINT_GROUPS))
    else $error("varint group index out of range");

endmodule

// ----- rtl/wbrp_queue.sv -----
// Short result queue between the parser front and the output stage.
// Depends on wbrp_pkg.
module wbrp_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  wbrp_pkg::result_t push_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output wbrp_pkg::result_t pop_data_o
);
  import wbrp_pkg::*;

  localparam int unsigned PTR_W = $clog2(QDEPTH);

  result_t            mem_q [QDEPTH];
  logic [PTR_W-1:0]   wr_q, rd_q;
  logic [PTR_W:0]     cnt_q;
  logic               do_push, do_pop;

  assign full_o     = (cnt_q == (PTR_W+1)'(QDEPTH));
  assign empty_o    = (cnt_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + PTR_W'(1);
      if (do_pop)  rd_q <= rd_q + PTR_W'(1);
      cnt_q <= cnt_q + (PTR_W+1)'(do_push) - (PTR_W+1)'(do_pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into a full result queue");

endmodule

// ----- rtl/wbrp_back.sv -----
// Output stage of the record parser: registers one result and drives the master stream.
// Depends on wbrp_pkg.
module wbrp_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_empty_i,
  input  wbrp_pkg::result_t q_data_i,
  output logic              q_pop_o,
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  output logic [47:0]       m_axis_tdata_o,
  output logic [4:0]        m_axis_tuser_o,
  output logic              m_axis_tlast_o
);
  import wbrp_pkg::*;

  result_t out_q;
  logic    vld_q;
  logic    load;

  assign load    = !vld_q || m_axis_tready_i;
  assign q_pop_o = load && !q_empty_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (load) begin
      vld_q <= !q_empty_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      out_q <= q_data_i;
    end
  end

  assign m_axis_tvalid_o = vld_q;
  assign m_axis_tdata_o  = {5'b0, out_q.format_error, out_q.op_accepted, out_q.op_end,
                            out_q.sequence_number, out_q.payload_byte};
  assign m_axis_tuser_o  = {out_q.op_code, out_q.kind};
  assign m_axis_tlast_o  = out_q.record_end;

endmodule

// ----- rtl/write_batch_record_parser.sv -----
// Top level of the write batch record parser: parser front, result queue, output stage.
// Depends on wbrp_pkg, wbrp_front, wbrp_queue and wbrp_back.
//
//  channel  dir  handshake               contents
//  s_axis   in   tvalid/tready           one record byte, tlast on the record's final byte
//  m_axis   out  tvalid/tready           one parse result, tlast on the record end
//
// One byte is taken per cycle while the result queue has room. A result is written
// to the queue when its byte is transferred and is then loaded into the output
// register. The front holds its parse state in registers and updates it in the
// cycle of the transfer, so the sustained rate is one byte per cycle unless the
// result queue is full. s_axis_tready_o drops only while the four-entry result
// queue is full, i.e. under output backpressure. Reset clears the parse state to
// the header phase and empties the queue and output register.
module write_batch_record_parser #(
  parameter int unsigned HEADER_BYTES      = 12,
  parameter int unsigned MAX_VARINT_GROUPS = 8,
  parameter int unsigned MARKER_KEY_LENGTH = 28
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,  // [7:0] data_byte
  input  logic        s_axis_tlast_i,  // last_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o,  // [7:0] payload_byte, [39:8] sequence_number,
                                       // [40] op_end, [41] op_accepted,
                                       // [42] format_error, [47:43] zero
  output logic [4:0]  m_axis_tuser_o,  // [2:0] kind, [4:3] op_code
  output logic        m_axis_tlast_o   // record_end
);
  import wbrp_pkg::*;

  logic    push, q_full, q_empty, q_pop;
  result_t push_data, pop_data;

  // Parser front: classify each byte and update the record state.
  wbrp_front #(
    .HEADER_BYTES     (HEADER_BYTES),
    .MAX_VARINT_GROUPS(MAX_VARINT_GROUPS),
    .MARKER_KEY_LENGTH(MARKER_KEY_LENGTH)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid_i),
    .ready_o (s_axis_tready_o),
    .data_i  (s_axis_tdata_i),
    .last_i  (s_axis_tlast_i),
    .q_full_i(q_full),
    .push_o  (push),
    .res_o   (push_data)
  );

  // Decouple the front from output stalls.
  wbrp_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .empty_o    (q_empty),
    .pop_data_o (pop_data)
  );

  // Output register: hold a result until the sink takes the transfer.
  wbrp_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_empty_i      (q_empty),
    .q_data_i       (pop_data),
    .q_pop_o        (q_pop),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

endmodule
